// ----- src/mpp_pkg.sv -----
// Shared constants, codes and types of the motor position PID controller.
`default_nettype none
package mpp_pkg;

	localparam int unsigned POSITION_WIDTH_DEF = 16;
	localparam int unsigned INTEGRAL_WIDTH_DEF = 40;

	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned DIR_W    = 2;
	localparam int unsigned DUTY_W   = 10;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;
	localparam logic [DUTY_W-1:0] DUTY_MIN = 10'd85;

	// Integral product magnitude limit is 2**PROD_LIMIT_EXP
	localparam int unsigned PROD_LIMIT_EXP = 62;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOP = 2'd0,
		DIR_CCW  = 2'd1,
		DIR_CW   = 2'd2
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN     = 2'd0,
		CFG_INTEGRAL_GAIN = 2'd1,
		CFG_DERIV_GAIN    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} gains_t;

endpackage
`default_nettype wire

// ----- src/mpp_if.sv -----
// Valid/ready channel interfaces for position samples and drive commands.
`default_nettype none
interface mpp_sample_if
	import mpp_pkg::*;
	#(parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF) ();

	logic                             valid;
	logic                             ready;
	logic signed [POSITION_WIDTH-1:0] target_pos;
	logic signed [POSITION_WIDTH-1:0] measured_pos;

	modport source (output valid, output target_pos, output measured_pos, input ready);
	modport sink (input valid, input target_pos, input measured_pos, output ready);

endinterface

interface mpp_drive_if
	import mpp_pkg::*;
	();

	logic              valid;
	logic              ready;
	logic [DIR_W-1:0]  direction;
	logic [DUTY_W-1:0] duty;

	modport source (output valid, output direction, output duty, input ready);
	modport sink (input valid, input direction, input duty, output ready);

endinterface
`default_nettype wire

// ----- src/mpp_error_integ.sv -----
// Error, derivative difference and saturating trapezoidal integral stage.
`default_nettype none
module mpp_error_integ
	import mpp_pkg::*;
	#(
		parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF,
		parameter int unsigned INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
	) (
		input  wire logic                             clk,
		input  wire logic                             arst_n,
		input  wire logic                             take,
		input  wire logic signed [POSITION_WIDTH-1:0] target_pos,
		input  wire logic signed [POSITION_WIDTH-1:0] measured_pos,
		output logic signed [POSITION_WIDTH:0]        err_s2,
		output logic signed [POSITION_WIDTH+1:0]      dif_s2,
		output logic signed [INTEGRAL_WIDTH-1:0]      integ_s2
	);

	localparam int unsigned PW = POSITION_WIDTH;
	localparam int unsigned IW = INTEGRAL_WIDTH;
	localparam int unsigned SW = ((IW > PW + 2) ? IW : PW + 2) + 1;

	localparam logic signed [SW-1:0] IMAX = (SW'(1) << (IW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] IMIN = -(SW'(1) << (IW - 1));

	logic signed [PW:0]   last_error_q;
	logic signed [IW-1:0] integral_q;

	logic signed [PW:0]   err;
	logic signed [PW+1:0] inc;
	logic signed [PW+1:0] dif;
	logic signed [SW-1:0] sum_wide;
	logic signed [IW-1:0] integ_next;

	always_comb begin
		err = (PW+1)'(target_pos) - (PW+1)'(measured_pos);
		inc = (PW+2)'(err) + (PW+2)'(last_error_q);
		dif = (PW+2)'(err) - (PW+2)'(last_error_q);
		sum_wide = SW'(integral_q) + SW'(inc);
		// clamp to the accumulator range
		priority if (sum_wide > IMAX) begin
			integ_next = IMAX[IW-1:0];
		end else if (sum_wide < IMIN) begin
			integ_next = IMIN[IW-1:0];
		end else begin
			integ_next = sum_wide[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			integral_q   <= '0;
		end else if (take) begin
			last_error_q <= err;
			integral_q   <= integ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_s2   <= err;
			dif_s2   <= dif;
			integ_s2 <= integ_next;
		end
	end

endmodule
`default_nettype wire

// ----- src/mpp_control.sv -----
// Gain products, control sum, direction and clamped duty.
`default_nettype none
module mpp_control
	import mpp_pkg::*;
	#(
		parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF,
		parameter int unsigned INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
	) (
		input  wire logic                             clk,
		input  wire logic                             take_prod,
		input  wire logic                             take_out,
		input  wire gains_t                           gains,
		input  wire logic signed [POSITION_WIDTH:0]   err_s2,
		input  wire logic signed [POSITION_WIDTH+1:0] dif_s2,
		input  wire logic signed [INTEGRAL_WIDTH-1:0] integ_s2,
		output logic [DIR_W-1:0]                      direction,
		output logic [DUTY_W-1:0]                     duty
	);

	localparam int unsigned PW = POSITION_WIDTH;
	localparam int unsigned IW = INTEGRAL_WIDTH;
	localparam int unsigned GW = GAIN_W;
	localparam int unsigned PPW = GW + PW + 2;
	localparam int unsigned DPW = GW + PW + 3;
	localparam int unsigned IPW = GW + IW + 1;
	localparam int unsigned TW = ((IPW > 64) ? IPW : 64) + 2;
	localparam int unsigned QW = TW - 8;

	localparam logic signed [TW-1:0] PLIM_POS = TW'(1) << PROD_LIMIT_EXP;
	localparam logic signed [TW-1:0] PLIM_NEG = -(TW'(1) << PROD_LIMIT_EXP);

	logic signed [PPW-1:0] prop_prod;
	logic signed [DPW-1:0] deriv_prod;
	logic signed [IPW-1:0] integ_prod;
	logic signed [TW-1:0]  integ_wide;
	logic signed [TW-1:0]  integ_sat;

	logic signed [PPW-1:0] prop_s3;
	logic signed [DPW-1:0] deriv_s3;
	logic signed [TW-1:0]  integ_s3;

	logic signed [TW-1:0] total;
	logic [TW-1:0]        mag;
	logic [QW-1:0]        quot;
	logic [DUTY_W-1:0]    duty_next;
	dir_t                 dir_next;

	always_comb begin
		prop_prod  = $signed({1'b0, gains.prop}) * err_s2;
		deriv_prod = $signed({1'b0, gains.deriv}) * dif_s2;
		integ_prod = $signed({1'b0, gains.integ}) * integ_s2;
		integ_wide = TW'(integ_prod);
		priority if (integ_wide > PLIM_POS) begin
			integ_sat = PLIM_POS;
		end else if (integ_wide < PLIM_NEG) begin
			integ_sat = PLIM_NEG;
		end else begin
			integ_sat = integ_wide;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prod) begin
			prop_s3  <= prop_prod;
			deriv_s3 <= deriv_prod;
			integ_s3 <= integ_sat;
		end
	end

	always_comb begin
		total = TW'(prop_s3) + integ_s3 + TW'(deriv_s3);
		mag   = total[TW-1] ? TW'(-total) : TW'(total);
		quot  = mag[TW-1:8];
		priority if (total == '0) begin
			dir_next = DIR_STOP;
		end else if (total[TW-1]) begin
			dir_next = DIR_CW;
		end else begin
			dir_next = DIR_CCW;
		end
		priority if (quot > QW'(DUTY_MAX)) begin
			duty_next = DUTY_MAX;
		end else if (quot < QW'(DUTY_MIN)) begin
			duty_next = DUTY_MIN;
		end else begin
			duty_next = quot[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			direction <= dir_next;
			duty      <= duty_next;
		end
	end

endmodule
`default_nettype wire

// ----- src/motor_position_pid.sv -----
// Top level of the motor position PID controller.
//
//   channel   dir   fields                       transfer
//   samples   in    target_pos, measured_pos     valid & ready
//   results   out   direction, duty              valid & ready
//   cfg       in    cfg_index, cfg_data          cfg_we
//
// One sample per cycle sustained while results are taken. A result is valid once
// its sample has passed the input register, the error/integral register, the
// product register and then the result register.
// Reset clears the gains, the last error, the integral and all valid bits.
// A stalled result holds every stage behind it; bubbles are squeezed out.
`default_nettype none
module motor_position_pid
	import mpp_pkg::*;
	#(
		parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF,
		parameter int unsigned INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
	) (
		input  wire logic                  clk,
		input  wire logic                  arst_n,
		input  wire logic                  cfg_we,
		input  wire logic [CFG_IDX_W-1:0]  cfg_index,
		input  wire logic [GAIN_W-1:0]     cfg_data,
		mpp_sample_if.sink                 samples,
		mpp_drive_if.source                results
	);

	gains_t gains_q;

	logic v_s1, v_s2, v_s3, v_out_q;
	logic en_s1, en_s2, en_s3, en_out;

	logic signed [POSITION_WIDTH-1:0] target_s1;
	logic signed [POSITION_WIDTH-1:0] measured_s1;

	logic signed [POSITION_WIDTH:0]   err_s2;
	logic signed [POSITION_WIDTH+1:0] dif_s2;
	logic signed [INTEGRAL_WIDTH-1:0] integ_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PROP_GAIN:     gains_q.prop  <= cfg_data;
				CFG_INTEGRAL_GAIN: gains_q.integ <= cfg_data;
				CFG_DERIV_GAIN:    gains_q.deriv <= cfg_data;
				default:           gains_q       <= gains_q;
			endcase
		end
	end

	// a stage advances when it is empty or the next one advances
	assign en_out = !v_out_q || results.ready;
	assign en_s3  = !v_s3 || en_out;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign samples.ready = en_s1;
	assign results.valid = v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1    <= samples.valid;
			if (en_s2)  v_s2    <= v_s1;
			if (en_s3)  v_s3    <= v_s2;
			if (en_out) v_out_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && en_s1) begin
			target_s1   <= samples.target_pos;
			measured_s1 <= samples.measured_pos;
		end
	end

	mpp_error_integ #(
		.POSITION_WIDTH (POSITION_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_error_integ (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (v_s1 && en_s2),
		.target_pos   (target_s1),
		.measured_pos (measured_s1),
		.err_s2       (err_s2),
		.dif_s2       (dif_s2),
		.integ_s2     (integ_s2)
	);

	mpp_control #(
		.POSITION_WIDTH (POSITION_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_control (
		.clk       (clk),
		.take_prod (v_s2 && en_s3),
		.take_out  (v_s3 && en_out),
		.gains     (gains_q),
		.err_s2    (err_s2),
		.dif_s2    (dif_s2),
		.integ_s2  (integ_s2),
		.direction (results.direction),
		.duty      (results.duty)
	);

endmodule
`default_nettype wire
